[src/edge_list_shuffle_macros.svh]
// assertion macros for the edge list shuffler
// no dependencies, taken in by the files that carry assertions
`ifndef EDGE_LIST_SHUFFLE_MACROS_SVH
`define EDGE_LIST_SHUFFLE_MACROS_SVH

// same-cycle implication
`define ELS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ELS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/els_pkg.sv]
// shared types, constants and helpers of the edge list shuffler
// no dependencies
package els_pkg;

  localparam int unsigned MAX_EDGES_DEF      = 64;
  localparam int unsigned NODE_BITS          = 10;
  localparam int unsigned WEIGHT_BITS        = 16;
  localparam int unsigned LFSR_BITS          = 32;
  localparam int unsigned MOD_BITS_PER_CYCLE = 4;
  localparam int unsigned MOD_CYCLES         = LFSR_BITS / MOD_BITS_PER_CYCLE;

  // x^32 + x^22 + x^2 + x + 1, galois form shifting right
  localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_BITS-1:0] LFSR_ONE  = 32'h0000_0001;

  typedef struct packed {
    logic [NODE_BITS-1:0]   start_node;
    logic [NODE_BITS-1:0]   end_node;
    logic [WEIGHT_BITS-1:0] edge_weight;
    logic                   last_edge;
  } edge_in_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   out_start_node;
    logic [NODE_BITS-1:0]   out_end_node;
    logic [WEIGHT_BITS-1:0] out_weight;
    logic                   out_last;
    logic                   overflowed;
  } edge_out_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   start_node;
    logic [NODE_BITS-1:0]   end_node;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_entry_t;

  localparam int unsigned ENTRY_BITS = $bits(edge_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TEST,
    ST_DRAW,
    ST_MOD,
    ST_RD_HI,
    ST_RD_J,
    ST_WR_HI,
    ST_WR_J,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;       // store the accepted word
    logic shuf_init;  // i <= count, readout index <= 0
    logic draw;       // step the lfsr and start the remainder unit
    logic rd_hi;      // read entry i-1
    logic rd_j;       // read entry j, hold entry i-1
    logic wr_hi;      // entry i-1 <= entry j
    logic wr_j;       // entry j <= old entry i-1, i <= i-1
    logic rd_out;     // read entry at readout index
    logic cap_out;    // load output register
    logic out_pop;    // output word taken
    logic clear;      // empty the list
  } ctrl_cmd_t;

  typedef struct packed {
    logic i_gt1;
    logic mod_done;
    logic out_is_last;
  } ctrl_status_t;

  function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] v);
    logic [LFSR_BITS-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

[src/els_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module els_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/els_mod.sv]
// iterative remainder unit: 32-bit draw mod a small divisor, four bits a cycle
// depends on els_pkg
module els_mod #(
  parameter int unsigned DIV_BITS = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [els_pkg::LFSR_BITS-1:0]  dividend,
  input  logic [DIV_BITS-1:0]            divisor,
  output logic                           done,
  output logic [DIV_BITS-1:0]            rem
);

  localparam int unsigned RW    = DIV_BITS + 1;
  localparam int unsigned CNT_W = $clog2(els_pkg::MOD_CYCLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(els_pkg::MOD_CYCLES - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [els_pkg::LFSR_BITS-1:0] dvd;
  logic [RW-1:0]                 rem_acc;
  logic [RW-1:0]                 rem_next;
  logic [DIV_BITS-1:0]           div_q;

  // restoring remainder, msb first, one subtract per bit
  always_comb begin
    logic [RW-1:0] r;
    logic [RW-1:0] t;
    r = rem_acc;
    for (int s = 0; s < int'(els_pkg::MOD_BITS_PER_CYCLE); s++) begin
      t = {r[RW-2:0], dvd[els_pkg::LFSR_BITS-1-s]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r = t;
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_acc <= '0;
      dvd     <= dividend;
      div_q   <= divisor;
    end else if (busy) begin
      rem_acc <= rem_next;
      dvd     <= dvd << els_pkg::MOD_BITS_PER_CYCLE;
    end
  end

  assign rem = rem_acc[DIV_BITS-1:0];

endmodule

[src/els_dp.sv]
// datapath: edge store, count, lfsr, swap registers and output register
// depends on els_pkg, els_ram, els_mod
module els_dp #(
  parameter int unsigned MAX_EDGES = els_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  els_pkg::ctrl_cmd_t            cmd,
  output els_pkg::ctrl_status_t         status,
  input  els_pkg::edge_in_t             in_data,
  input  logic                          cfg_we,
  input  logic [els_pkg::LFSR_BITS-1:0] cfg_wdata,
  output logic                          out_valid,
  output els_pkg::edge_out_t            out_data
);

  localparam int unsigned AW = $clog2(MAX_EDGES);
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_EDGES);

  logic [CW-1:0]                 edge_count;
  logic                          overflow_flag;
  logic [els_pkg::LFSR_BITS-1:0] lfsr_value;
  logic [els_pkg::LFSR_BITS-1:0] lfsr_next;
  logic [CW-1:0]                 shuf_i;
  logic [CW-1:0]                 i_minus1;
  logic [AW-1:0]                 hi_idx;
  logic [AW-1:0]                 rd_k;
  logic [CW-1:0]                 k_plus1;
  logic [CW-1:0]                 mod_rem;
  logic                          mod_done;
  logic [AW-1:0]                 j_idx;
  els_pkg::edge_entry_t          tmp_hi;
  els_pkg::edge_entry_t          in_entry;
  els_pkg::edge_entry_t          rd_entry;
  logic                          store_full;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [els_pkg::ENTRY_BITS-1:0]   ram_wdata;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic [els_pkg::ENTRY_BITS-1:0]   ram_rdata;

  assign store_full = (edge_count == CNT_FULL);
  assign i_minus1   = shuf_i - CW'(1);
  assign hi_idx     = i_minus1[AW-1:0];
  assign j_idx      = mod_rem[AW-1:0];
  assign k_plus1    = CW'(rd_k) + CW'(1);
  assign lfsr_next  = els_pkg::lfsr_step(lfsr_value);
  assign rd_entry   = els_pkg::edge_entry_t'(ram_rdata);

  assign in_entry.start_node = in_data.start_node;
  assign in_entry.end_node   = in_data.end_node;
  assign in_entry.weight     = in_data.edge_weight;

  assign status.i_gt1       = (shuf_i > CW'(1));
  assign status.mod_done    = mod_done;
  assign status.out_is_last = (k_plus1 == edge_count);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = edge_count[AW-1:0];
    ram_wdata = in_entry;
    priority if (cmd.load) begin
      ram_we = !store_full;
    end else if (cmd.wr_hi) begin
      ram_we    = 1'b1;
      ram_waddr = hi_idx;
      ram_wdata = ram_rdata;
    end else if (cmd.wr_j) begin
      ram_we    = 1'b1;
      ram_waddr = j_idx;
      ram_wdata = tmp_hi;
    end else begin
      ram_we = 1'b0;
    end
  end

  always_comb begin
    ram_re = cmd.rd_hi | cmd.rd_j | cmd.rd_out;
    priority if (cmd.rd_hi) begin
      ram_raddr = hi_idx;
    end else if (cmd.rd_j) begin
      ram_raddr = j_idx;
    end else begin
      ram_raddr = rd_k;
    end
  end

  els_ram #(
    .WIDTH (els_pkg::ENTRY_BITS),
    .DEPTH (MAX_EDGES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  els_mod #(
    .DIV_BITS (CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.draw),
    .dividend (lfsr_next),
    .divisor  (shuf_i),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      overflow_flag <= 1'b0;
      lfsr_value    <= els_pkg::LFSR_ONE;
      shuf_i        <= '0;
      rd_k          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        lfsr_value <= (cfg_wdata == '0) ? els_pkg::LFSR_ONE : cfg_wdata;
      end else if (cmd.draw) begin
        lfsr_value <= lfsr_next;
      end

      if (cmd.clear) begin
        edge_count    <= '0;
        overflow_flag <= 1'b0;
      end else if (cmd.load) begin
        if (store_full) begin
          overflow_flag <= 1'b1;
        end else begin
          edge_count <= edge_count + CW'(1);
        end
      end

      if (cmd.shuf_init) begin
        shuf_i <= edge_count;
        rd_k   <= '0;
      end else begin
        if (cmd.wr_j) begin
          shuf_i <= i_minus1;
        end
        if (cmd.out_pop) begin
          rd_k <= rd_k + AW'(1);
        end
      end

      if (cmd.cap_out) begin
        out_valid <= 1'b1;
      end else if (cmd.out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_j) begin
      tmp_hi <= rd_entry;
    end
    if (cmd.cap_out) begin
      out_data.out_start_node <= rd_entry.start_node;
      out_data.out_end_node   <= rd_entry.end_node;
      out_data.out_weight     <= rd_entry.weight;
      out_data.out_last       <= status.out_is_last;
      out_data.overflowed     <= overflow_flag;
    end
  end

endmodule

[src/els_ctrl.sv]
// controller: sequences load, shuffle swaps and readout
// depends on els_pkg
module els_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  last_edge,
  input  logic                  out_ready,
  input  els_pkg::ctrl_status_t status,
  output logic                  in_ready,
  output els_pkg::ctrl_cmd_t    cmd
);

  els_pkg::ctrl_state_t state;
  els_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= els_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      els_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_edge) begin
            state_next = els_pkg::ST_SETUP;
          end
        end
      end
      els_pkg::ST_SETUP: begin
        cmd.shuf_init = 1'b1;
        state_next    = els_pkg::ST_TEST;
      end
      els_pkg::ST_TEST: begin
        state_next = status.i_gt1 ? els_pkg::ST_DRAW : els_pkg::ST_OUT_RD;
      end
      els_pkg::ST_DRAW: begin
        cmd.draw   = 1'b1;
        state_next = els_pkg::ST_MOD;
      end
      els_pkg::ST_MOD: begin
        if (status.mod_done) begin
          state_next = els_pkg::ST_RD_HI;
        end
      end
      els_pkg::ST_RD_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = els_pkg::ST_RD_J;
      end
      els_pkg::ST_RD_J: begin
        cmd.rd_j   = 1'b1;
        state_next = els_pkg::ST_WR_HI;
      end
      els_pkg::ST_WR_HI: begin
        cmd.wr_hi  = 1'b1;
        state_next = els_pkg::ST_WR_J;
      end
      els_pkg::ST_WR_J: begin
        cmd.wr_j   = 1'b1;
        state_next = els_pkg::ST_TEST;
      end
      els_pkg::ST_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = els_pkg::ST_OUT_CAP;
      end
      els_pkg::ST_OUT_CAP: begin
        cmd.cap_out = 1'b1;
        state_next  = els_pkg::ST_OUT_WAIT;
      end
      els_pkg::ST_OUT_WAIT: begin
        if (out_ready) begin
          cmd.out_pop = 1'b1;
          if (status.out_is_last) begin
            cmd.clear  = 1'b1;
            state_next = els_pkg::ST_IDLE;
          end else begin
            state_next = els_pkg::ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = els_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/edge_list_shuffle.sv]
// top level of the edge list shuffler
// depends on els_pkg, els_ctrl, els_dp and edge_list_shuffle_macros.svh
`include "edge_list_shuffle_macros.svh"

// Edge list shuffler. Edges (start node, end node, weight) come in one word
// per cycle and are stored in arrival order, up to MAX_EDGES of them; words
// beyond that are dropped and every word of that list reads back with
// overflowed set. The word marked last_edge (stored too, if there is room)
// starts a Fisher-Yates shuffle: for i = count-1 down to 1, entry i swaps
// with entry (draw mod (i+1)), each draw one step of a 32-bit Galois lfsr
// (taps 0x80200003) that keeps running from list to list. The list is then
// sent out in shuffled order with out_last on its final word and empties.
// Writing cfg_wdata with cfg_we reloads the lfsr at once (a zero seed loads
// 1); write it only while the block is idle. After the last word, SETUP
// sets up the shuffle and TEST tests the index, ending the shuffle once no
// swap is left. Each swap runs TEST, DRAW, MOD waiting on the remainder
// unit, which handles four bits of the 32-bit draw a cycle and then flags
// done, then RD_HI, RD_J, WR_HI, WR_J, as the store with one read and one
// write port needs two reads and two writes. Readout runs OUT_RD, OUT_CAP
// and OUT_WAIT per word, from the registered store read and the output
// register, and holds in OUT_WAIT while out_ready is low. New words are
// taken only once the previous list has been fully sent.
module edge_list_shuffle #(
  parameter int unsigned MAX_EDGES = els_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  els_pkg::edge_in_t             in_data,
  // output words
  output logic                          out_valid,
  input  logic                          out_ready,
  output els_pkg::edge_out_t            out_data,
  // seed register
  input  logic                          cfg_we,
  input  logic [els_pkg::LFSR_BITS-1:0] cfg_wdata
);

  els_pkg::ctrl_cmd_t    cmd;
  els_pkg::ctrl_status_t status;

  // state machine: owns the handshakes and the step order
  els_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_edge (in_data.last_edge),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // store, counters, lfsr, remainder unit and output register
  els_dp #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // no word is taken in while an output word waits
  `ELS_ASSERT_IMP(a_no_load_while_out, clk, rst, out_valid, !in_ready,
    "load during readout")
  // the final word of a list hands control back to loading
  `ELS_ASSERT_NEXT(a_idle_after_last, clk, rst,
    out_valid && out_ready && out_data.out_last, in_ready, "not idle after last word")
  // a word without last_edge only loads
  `ELS_ASSERT_NEXT(a_keep_loading, clk, rst,
    in_valid && in_ready && !in_data.last_edge, in_ready, "left load after plain word")
  // the remainder unit only finishes while shuffling
  `ELS_ASSERT_IMP(a_mod_in_shuffle, clk, rst, status.mod_done, !in_ready && !out_valid,
    "remainder done outside shuffle")

endmodule

[tb/edge_list_shuffle_checker.sv]
`timescale 1ns / 100ps
// checker for the edge list shuffler: follows both word channels and the seed port
// depends on els_pkg; predicts each shuffled list and compares it word by word

module edge_list_shuffle_checker #(
  parameter int unsigned CAPACITY = els_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  els_pkg::edge_in_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  els_pkg::edge_out_t            out_data,
  input  logic                          cfg_we,
  input  logic [els_pkg::LFSR_BITS-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            pending_words
);

  import els_pkg::*;

  edge_entry_t            list_store [CAPACITY];
  int unsigned            list_len;
  logic [LFSR_BITS-1:0]   lfsr_state;
  logic                   list_dropped;
  edge_out_t              shuffled_q [$];
  int                     mismatches = 0;
  int                     waiting = 0;

  assign fail_count    = mismatches;
  assign pending_words = waiting;

  // one right shift of the galois lfsr
  function automatic logic [LFSR_BITS-1:0] advance_lfsr(input logic [LFSR_BITS-1:0] v);
    return {1'b0, v[LFSR_BITS-1:1]} ^ (v[0] ? LFSR_TAPS : '0);
  endfunction

  // fisher-yates over the stored list, then queue the readout
  task automatic shuffle_list();
    int unsigned   i;
    int unsigned   j;
    edge_entry_t   t;
    edge_out_t     w;
    for (i = list_len; i > 1; i--) begin
      lfsr_state = advance_lfsr(lfsr_state);
      j = lfsr_state % i;
      t = list_store[i-1];
      list_store[i-1] = list_store[j];
      list_store[j] = t;
    end
    for (i = 0; i < list_len; i++) begin
      w.out_start_node = list_store[i].start_node;
      w.out_end_node   = list_store[i].end_node;
      w.out_weight     = list_store[i].weight;
      w.out_last       = (i + 1 == list_len);
      w.overflowed     = list_dropped;
      shuffled_q.push_back(w);
    end
    list_len     = 0;
    list_dropped = 1'b0;
  endtask

  task automatic take_edge(input edge_in_t w);
    if (list_len >= CAPACITY) begin
      list_dropped = 1'b1;
    end else begin
      list_store[list_len].start_node = w.start_node;
      list_store[list_len].end_node   = w.end_node;
      list_store[list_len].weight     = w.edge_weight;
      list_len++;
    end
    if (w.last_edge) begin
      shuffle_list();
    end
  endtask

  task automatic check_word(input edge_out_t got);
    edge_out_t want;
    if (shuffled_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: output word with none expected: start %0d end %0d weight %0d last %0b ovf %0b",
                 $realtime, got.out_start_node, got.out_end_node, got.out_weight,
                 got.out_last, got.overflowed);
      end
    end else begin
      want = shuffled_q.pop_front();
      if (got.out_start_node !== want.out_start_node || got.out_end_node !== want.out_end_node ||
          got.out_weight !== want.out_weight || got.out_last !== want.out_last ||
          got.overflowed !== want.overflowed) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: word mismatch exp start %0d end %0d weight %0d last %0b ovf %0b",
                   $realtime, want.out_start_node, want.out_end_node, want.out_weight,
                   want.out_last, want.overflowed);
          $display("%0t:                got start %0d end %0d weight %0d last %0b ovf %0b",
                   $realtime, got.out_start_node, got.out_end_node, got.out_weight,
                   got.out_last, got.overflowed);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_len     = 0;
      list_dropped = 1'b0;
      lfsr_state   = 32'd1;
      shuffled_q.delete();
    end else begin
      // a zero seed would lock the lfsr, so it loads 1
      if (cfg_we) begin
        lfsr_state = (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
      end
      if (out_valid && out_ready) begin
        check_word(out_data);
      end
      if (in_valid && in_ready) begin
        take_edge(in_data);
      end
    end
    waiting = shuffled_q.size();
  end

endmodule

[tb/edge_list_shuffle_tb.sv]
`timescale 1ns / 100ps
// top of the edge list shuffler testbench: clock, reset, stimulus and verdict
// depends on els_pkg, edge_list_shuffle and edge_list_shuffle_checker

module edge_list_shuffle_tb;

  import els_pkg::*;

  // cycles to let the block finish clearing after its last output word
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned NODE_MAX      = (1 << NODE_BITS) - 1;
  localparam int unsigned WEIGHT_MAX    = (1 << WEIGHT_BITS) - 1;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  edge_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  edge_out_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [LFSR_BITS-1:0] cfg_wdata = '0;

  bit                   idle_on   = 1'b0;
  int unsigned          ready_hold = 0;
  int                   fail_count;
  int                   pending_words;

  always #4 clk = ~clk;

  edge_list_shuffle #(
    .MAX_EDGES(MAX_EDGES_DEF)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  edge_list_shuffle_checker #(
    .CAPACITY(MAX_EDGES_DEF)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  // output side: alternate random stall bursts with ready runs,
  // always ready once idling is switched off
  always @(negedge clk) begin
    if (!idle_on) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 14);
      end else begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(1, 30);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // a field value that hits zero and all ones now and then
  function automatic int unsigned pick_field(input int unsigned top);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // present one word; returns at the falling edge after it was taken, with
  // valid still high so a following word can go straight out
  task automatic send_edge(input int unsigned from_node, input int unsigned to_node,
                           input int unsigned wt, input bit is_last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_data.start_node  <= NODE_BITS'(from_node);
    in_data.end_node    <= NODE_BITS'(to_node);
    in_data.edge_weight <= WEIGHT_BITS'(wt);
    in_data.last_edge   <= is_last;
    in_valid            <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // a whole list of random edges, last_edge on the final word
  task automatic send_random_list(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_edge(pick_field(NODE_MAX), pick_field(NODE_MAX), pick_field(WEIGHT_MAX),
                k + 1 == len);
    end
  endtask

  // drop valid, let every expected word drain and the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // new seed, only once the block is idle
  task automatic write_seed(input logic [LFSR_BITS-1:0] seed);
    wait_drained();
    cfg_wdata <= seed;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned items;
    int unsigned len;

    repeat (4) @(negedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;
    @(negedge clk);

    // reset seed: a single-word list (no swaps) with all-zero fields
    send_edge(0, 0, 0, 1'b1);
    // two words with every field at its maximum
    send_edge(NODE_MAX, NODE_MAX, WEIGHT_MAX, 1'b0);
    send_edge(NODE_MAX, NODE_MAX, WEIGHT_MAX, 1'b1);
    // alternating bit patterns
    send_edge(0, NODE_MAX, 16'h5555, 1'b0);
    send_edge(NODE_MAX, 0, 16'hAAAA, 1'b0);
    send_edge(10'h2AA, 10'h155, 1, 1'b1);

    // zero seed falls back to 1
    write_seed('0);
    send_random_list(4);
    // seed extremes
    write_seed('1);
    send_random_list(5);
    write_seed(32'h8000_0000);
    send_random_list(3);

    // random phases, each under a fresh seed; one full list and one that
    // overruns the store so the final word is dropped too
    for (int p = 0; p < 5; p++) begin
      write_seed($urandom);
      if (p == 4) begin
        idle_on <= 1'b0;
      end
      if (p == 1) begin
        send_random_list(MAX_EDGES_DEF);
      end
      if (p == 2) begin
        send_random_list(MAX_EDGES_DEF + 1);
      end
      items = 0;
      while (items < 2) begin
        len = $urandom_range(1, 6);
        send_random_list(len);
        items += len;
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("edge_list_shuffle_tb OK");
    end else begin
      $display("edge_list_shuffle_tb NOT OK");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("edge_list_shuffle_tb NOT OK");
    $finish;
  end

endmodule
